/* design/lef_pkg.sv */
// Shared types and constants for the line editor escape filter.
package lef_pkg;

   localparam int DEFAULT_LINE_CAPACITY = 63;
   localparam int QUEUE_DEPTH           = 4;

   localparam logic [7:0] KEY_BS    = 8'h08;
   localparam logic [7:0] KEY_EOT   = 8'h04;
   localparam logic [7:0] KEY_LF    = 8'h0A;
   localparam logic [7:0] KEY_CR    = 8'h0D;
   localparam logic [7:0] KEY_ESC   = 8'h1B;
   localparam logic [7:0] KEY_LBRK  = 8'h5B;
   localparam logic [7:0] KEY_DEL   = 8'h7F;
   localparam logic [7:0] KEY_SPACE = 8'h20;
   localparam logic [7:0] PRINT_LO  = 8'd32;
   localparam logic [7:0] PRINT_HI  = 8'd126;
   localparam logic [7:0] FINAL_LO  = 8'h40;
   localparam logic [7:0] FINAL_HI  = 8'h7E;

   typedef enum logic [1:0] {
      KIND_ECHO = 2'd0,
      KIND_LINE = 2'd1,
      KIND_END  = 2'd2,
      KIND_EOF  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_ERASE = 2'd1,
      OP_EOF   = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] key;
   } cmd_type;

endpackage

/* design/lef_front.sv */
// Front end: escape-sequence tracking and key classification into commands.
module lef_front #(
   parameter int LINE_CAPACITY = lef_pkg::DEFAULT_LINE_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] key_byte
   input  logic             q_full,
   output logic             q_push,
   output lef_pkg::cmd_type q_cmd
);
   import lef_pkg::*;

   localparam int FILL_W = $clog2(LINE_CAPACITY + 1);

   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_ESC,
      PH_CSI
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      phase_in  = phase_ff;
      fill_in   = fill_ff;
      q_push    = 1'b0;
      q_cmd.op  = OP_STORE;
      q_cmd.key = req_tdata;
      if (accept) begin
         unique case (phase_ff)
            PH_ESC: begin
               phase_in = (req_tdata == KEY_LBRK) ? PH_CSI : PH_NORMAL;
            end
            PH_CSI: begin
               if (req_tdata >= FINAL_LO && req_tdata <= FINAL_HI) begin
                  phase_in = PH_NORMAL;
               end
            end
            default: begin
               if (req_tdata == KEY_ESC) begin
                  phase_in = PH_ESC;
               end else if (req_tdata == KEY_LF || req_tdata == KEY_CR) begin
                  q_push   = 1'b1;
                  q_cmd.op = OP_FLUSH;
                  fill_in  = '0;
               end else if (req_tdata == KEY_DEL || req_tdata == KEY_BS) begin
                  if (fill_ff != '0) begin
                     q_push   = 1'b1;
                     q_cmd.op = OP_ERASE;
                     fill_in  = fill_ff - 1'b1;
                  end
               end else if (req_tdata == KEY_EOT) begin
                  if (fill_ff == '0) begin
                     q_push   = 1'b1;
                     q_cmd.op = OP_EOF;
                  end
               end else if (req_tdata >= PRINT_LO && req_tdata <= PRINT_HI) begin
                  if (fill_ff < FILL_W'(LINE_CAPACITY)) begin
                     q_push   = 1'b1;
                     q_cmd.op = OP_STORE;
                     fill_in  = fill_ff + 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         fill_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(LINE_CAPACITY))
      else $error("front fill count beyond capacity");

   a_no_push_unless_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> accept && phase_ff == PH_NORMAL)
      else $error("command pushed outside a normal-phase request");

endmodule

/* design/lef_queue.sv */
// Short command queue between the front end and the back end.
module lef_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lef_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output lef_pkg::cmd_type head_cmd
);
   import lef_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign valid    = count_ff != '0;
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !valid))
      else $error("pop from an empty queue");

endmodule

/* design/lef_back.sv */
// Back end: line store, command sequencer and result register.
module lef_back #(
   parameter int LINE_CAPACITY = lef_pkg::DEFAULT_LINE_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  lef_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] data_byte, [13:8] line_length, [15:14] 0
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser    // [1:0] kind
);
   import lef_pkg::*;

   localparam int FILL_W = $clog2(LINE_CAPACITY + 1);
   localparam int IDX_W  = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERASE_SP,
      ST_ERASE_BS,
      ST_FLUSH_RD,
      ST_FLUSH_OUT,
      ST_END
   } state_type;

   state_type          state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic               last_ff, last_in;
   kind_type           kind_ff, kind_in;
   logic [7:0]         data_ff, data_in;
   logic [5:0]         len_ff, len_in;
   logic               out_free;
   logic               wr_en;
   logic [7:0]         rd_data_ff;
   logic [7:0]         line_mem [LINE_CAPACITY];

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {2'b00, len_ff, data_ff};
   assign wr_en      = state_ff == ST_IDLE && q_valid && out_free && q_cmd.op == OP_STORE;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[fill_ff[IDX_W-1:0]] <= q_cmd.key;
      end
      rd_data_ff <= line_mem[idx_ff[IDX_W-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_tready;
      last_in  = last_ff;
      kind_in  = kind_ff;
      data_in  = data_ff;
      len_in   = len_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  OP_STORE: begin
                     valid_in = 1'b1;
                     kind_in  = KIND_ECHO;
                     data_in  = q_cmd.key;
                     len_in   = '0;
                     last_in  = 1'b1;
                     fill_in  = fill_ff + 1'b1;
                  end
                  OP_ERASE: begin
                     valid_in = 1'b1;
                     kind_in  = KIND_ECHO;
                     data_in  = KEY_BS;
                     len_in   = '0;
                     last_in  = 1'b0;
                     fill_in  = fill_ff - 1'b1;
                     state_in = ST_ERASE_SP;
                  end
                  OP_EOF: begin
                     valid_in = 1'b1;
                     kind_in  = KIND_EOF;
                     data_in  = '0;
                     len_in   = '0;
                     last_in  = 1'b1;
                  end
                  default: begin
                     idx_in = '0;
                     if (fill_ff == '0) begin
                        valid_in = 1'b1;
                        kind_in  = KIND_END;
                        data_in  = KEY_LF;
                        len_in   = '0;
                        last_in  = 1'b1;
                     end else begin
                        state_in = ST_FLUSH_RD;
                     end
                  end
               endcase
            end
         end
         ST_ERASE_SP: begin
            if (out_free) begin
               valid_in = 1'b1;
               data_in  = KEY_SPACE;
               state_in = ST_ERASE_BS;
            end
         end
         ST_ERASE_BS: begin
            if (out_free) begin
               valid_in = 1'b1;
               data_in  = KEY_BS;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH_RD: begin
            state_in = ST_FLUSH_OUT;
         end
         ST_FLUSH_OUT: begin
            if (out_free) begin
               valid_in = 1'b1;
               kind_in  = KIND_LINE;
               data_in  = rd_data_ff;
               len_in   = '0;
               last_in  = 1'b0;
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == fill_ff) ? ST_END : ST_FLUSH_RD;
            end
         end
         ST_END: begin
            if (out_free) begin
               valid_in = 1'b1;
               kind_in  = KIND_END;
               data_in  = KEY_LF;
               len_in   = 6'(fill_ff);
               last_in  = 1'b1;
               fill_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      last_ff <= last_in;
      kind_ff <= kind_in;
      data_ff <= data_in;
      len_ff  <= len_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(LINE_CAPACITY))
      else $error("back fill count beyond capacity");

   a_erase_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERASE_SP || state_ff == ST_ERASE_BS) |-> valid_ff && !last_ff)
      else $error("erase sequence lost its pending echo");

   a_flush_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH_RD || state_ff == ST_FLUSH_OUT) |-> idx_ff < fill_ff)
      else $error("flush index beyond stored line");

   a_end_resets_fill: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_tready && kind_ff == KIND_END) |-> fill_ff == '0)
      else $error("line end delivered with bytes still stored");

endmodule

/* design/line_editor_escape_filter.sv */
// Top level of the line editor escape filter: front end, queue, back end.
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------
//  req_     | in  | tdata[7:0] key_byte
//  rsp_     | out | tdata[7:0] data_byte, [13:8] line_length; tuser kind;
//           |     | tlast on the final result of a request
//
// A request is taken whenever the four-entry command queue has room;
// escape bytes and bytes with no result never reach the queue.
// Single-result requests leave the result register one per cycle while rsp_
// is not stalled; an erase gives three results.
// A line flush reads the line store byte by byte: a registered memory read,
// then a result load for each byte, and after the last byte the line end.
// Synchronous reset clears phase, fill counts, queue and result valid; the line
// store is not cleared. A stall on rsp_ holds the back end; the front keeps
// taking requests until the queue fills.
module line_editor_escape_filter #(
   parameter int LINE_CAPACITY = lef_pkg::DEFAULT_LINE_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] key_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [13:8] line_length, [15:14] 0
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // [1:0] kind
);
   import lef_pkg::*;

   cmd_type push_cmd, head_cmd;
   logic    q_push, q_full, q_pop, q_valid;

   lef_front #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   lef_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (head_cmd)
   );

   lef_back #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
